// ===== rtl/mbgrip_pkg.sv =====
// Shared types and constants for the Modbus RTU gripper frame builder.
// Used by the controller, the datapath and the top level; no dependencies.
package mbgrip_pkg;

  localparam int unsigned FrameLen = 15;
  localparam int unsigned BodyLen  = 13;
  localparam int unsigned PosW     = 4;

  localparam logic [PosW-1:0] PosCrcLo = 4'(BodyLen);
  localparam logic [PosW-1:0] PosLast  = 4'(FrameLen - 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncWriteMulti = 8'h10;
  localparam logic [7:0] StartRegHi     = 8'h03;
  localparam logic [7:0] StartRegLo     = 8'hE8;
  localparam logic [7:0] RegCountHi     = 8'h00;
  localparam logic [7:0] RegCountLo     = 8'h03;
  localparam logic [7:0] ByteCount      = 8'h06;
  localparam logic [7:0] ActionGo       = 8'h09;
  localparam logic [7:0] PosOpen        = 8'h00;
  localparam logic [7:0] PosClose       = 8'hFF;
  localparam logic [7:0] SlaveAddrRst   = 8'h09;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture a new request, restart the frame
    logic advance;  // current beat taken, step to the next byte
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;     // current byte is the CRC high byte
  } status_t;

  // One byte through the reflected CRC-16/MODBUS register, bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbgrip_ctrl.sv =====
// Frame sequencer for the gripper frame builder: idle/send state machine.
// Depends on mbgrip_pkg for the command and status structs.
module mbgrip_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mbgrip_pkg::status_t status_i,
  output mbgrip_pkg::cmd_t    cmd_o
);
  import mbgrip_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StSend = 1'b1;

  logic state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StSend);

  always_comb begin
    cmd_o.load    = in_valid_i && in_ready_o;
    cmd_o.advance = out_valid_o && out_ready_i;
    state_d       = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSend;
      end
      StSend: begin
        // drop back to idle once the CRC high byte is taken
        if (out_ready_i && status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mbgrip_dp.sv =====
// Datapath for the gripper frame builder: request hold, byte counter,
// byte select and running CRC. Depends on mbgrip_pkg.
module mbgrip_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                operation_i,
  input  logic [7:0]          speed_i,
  input  logic [7:0]          force_req_i,
  input  mbgrip_pkg::cmd_t    cmd_i,
  output mbgrip_pkg::status_t status_o,
  output logic [7:0]          frame_byte_o,
  output logic                last_byte_o
);
  import mbgrip_pkg::*;

  logic [7:0]      slave_addr_q;
  logic            op_q;
  logic [7:0]      speed_q, force_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      byte_sel;

  always_comb begin
    unique case (pos_q)
      4'd0:    byte_sel = slave_addr_q;
      4'd1:    byte_sel = FuncWriteMulti;
      4'd2:    byte_sel = StartRegHi;
      4'd3:    byte_sel = StartRegLo;
      4'd4:    byte_sel = RegCountHi;
      4'd5:    byte_sel = RegCountLo;
      4'd6:    byte_sel = ByteCount;
      4'd7:    byte_sel = ActionGo;
      4'd8:    byte_sel = 8'h00;
      4'd9:    byte_sel = 8'h00;
      4'd10:   byte_sel = op_q ? PosClose : PosOpen;
      4'd11:   byte_sel = speed_q;
      4'd12:   byte_sel = force_q;
      4'd13:   byte_sel = crc_q[7:0];
      4'd14:   byte_sel = crc_q[15:8];
      default: byte_sel = 8'h00;
    endcase
  end

  assign frame_byte_o  = byte_sel;
  assign last_byte_o   = (pos_q == PosLast);
  assign status_o.last = last_byte_o;

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (cmd_i.load) begin
      pos_d = '0;
      crc_d = CrcInit;
    end else if (cmd_i.advance) begin
      pos_d = last_byte_o ? '0 : pos_q + 4'd1;
      // fold body bytes only; hold the CRC while its two bytes go out
      if (pos_q < PosCrcLo) crc_d = crc_feed(crc_q, byte_sel);
      if (last_byte_o) crc_d = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrRst;
      pos_q        <= '0;
      crc_q        <= CrcInit;
      op_q         <= 1'b0;
      speed_q      <= 8'h00;
      force_q      <= 8'h00;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      if (cfg_we_i) slave_addr_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        op_q    <= operation_i;
        speed_q <= speed_i;
        force_q <= force_req_i;
      end
    end
  end

endmodule

// ===== rtl/modbus_rtu_gripper_frame_builder.sv =====
// Top level of the Modbus RTU gripper frame builder.
// Instantiates mbgrip_ctrl and mbgrip_dp; depends on mbgrip_pkg.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries operation_i (0 open,
//   1 close), speed_i and force_req_i. Each accepted request produces one
//   15-byte write-multiple-registers frame on the byte channel
//   (out_valid_o/out_ready_i), one byte per beat, frame_byte_o in transmit
//   order and last_byte_o high on the CRC high byte.
//   The slave address register is written through cfg_we_i/cfg_wdata_i,
//   taking effect on the next frame; write it only while idle.
// Timing:
//   The first byte is valid the cycle after the request is accepted. The block
//   cannot take the next request until the frame's last byte is taken and it
//   is back in idle. The single byte counter and CRC register set this; the
//   CRC folds one byte per taken beat.
// Reset:
//   Clears the sequencer to idle, slave address to 9, CRC to 0xFFFF.
// Stall:
//   While out_ready_i is low the current byte and last flag hold, and no new
//   request is taken until the frame's last beat is accepted.
module modbus_rtu_gripper_frame_builder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] speed_i,
  input  logic [7:0] force_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);
  import mbgrip_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbgrip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbgrip_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (operation_i),
    .speed_i      (speed_i),
    .force_req_i  (force_req_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

  // Never take a request while a frame is in flight.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request channel ready during frame output");

  // A new frame starts at the address byte, never at the last byte.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (out_valid_o && !last_byte_o))
    else $error("frame did not start after request");

  // Taking the last beat ends the frame.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_byte_o) |=> (in_ready_o && !out_valid_o))
    else $error("frame did not end after last beat");

endmodule
